### rtl/irfd_pkg.sv
// ----------------------------------------------------------------------------
// irfd_pkg: shared types and codes for the icmp router forward decision
// action, verdict and icmp type codes, plus the compare unit request
// ----------------------------------------------------------------------------
package irfd_pkg;

    typedef logic [1:0]  t_action;
    typedef logic [2:0]  t_verdict;
    typedef logic [31:0] t_ipv4;
    typedef logic [47:0] t_mac;

    localparam t_action ACT_PACKET = 2'd0;
    localparam t_action ACT_ROUTE  = 2'd1;
    localparam t_action ACT_ARP    = 2'd2;
    localparam t_action ACT_OWN    = 2'd3;

    localparam t_verdict V_DROP     = 3'd0;
    localparam t_verdict V_REPLY    = 3'd1;
    localparam t_verdict V_FORWARD  = 3'd2;
    localparam t_verdict V_NO_ROUTE = 3'd3;
    localparam t_verdict V_NO_ARP   = 3'd4;
    localparam t_verdict V_WRITE    = 3'd5;

    localparam logic [7:0] KIND_ECHO_REQ = 8'd8;
    localparam logic [7:0] ICMP_REPLY    = 8'd0;

    localparam t_ipv4 IP_ZERO  = 32'h0000_0000;
    localparam t_ipv4 IP_ONES  = 32'hFFFF_FFFF;
    localparam t_mac  MAC_ZERO = 48'h0;

    // one masked compare of a key against a stored entry
    typedef struct packed {
        logic  valid;
        t_ipv4 key;
        t_ipv4 mask;
        t_ipv4 pattern;
    } t_cmp_req;

endpackage

### rtl/irfd_cmp.sv
// ----------------------------------------------------------------------------
// irfd_cmp: shared masked address compare
// hit when the entry is valid and (key & mask) equals the stored pattern
// ----------------------------------------------------------------------------
module irfd_cmp (
    input  irfd_pkg::t_cmp_req i_req,
    output logic               o_hit
);
    import irfd_pkg::*;

    t_ipv4 w_masked;

    assign w_masked = i_req.key & i_req.mask;
    assign o_hit    = i_req.valid && (w_masked == i_req.pattern);

endmodule

### rtl/icmp_router_forward_decision.sv
// ----------------------------------------------------------------------------
// icmp_router_forward_decision: ipv4 first-match route lookup with arp
// own address check, route table walk and arp walk through one compare unit
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_action .. i_entry_mac
//  out     | output    | o_out_valid / i_out_ready  | o_verdict .. o_next_hop_mac
//
//  a table write or a dropped packet goes straight to the done state; other
//  packets walk the own address, route and arp tables in turn, one table entry
//  per cycle through the shared compare and a registered read.
//  o_in_ready is high only while no item is in progress; a finished result
//  waits in the output register while the next item is taken.
//  a stalled output holds the sequencer in its final state until the register frees.
//  reset clears valid bits and control; table contents are not cleared.
// ----------------------------------------------------------------------------
module icmp_router_forward_decision #(
    parameter int ROUTE_ENTRIES = 8,
    parameter int ARP_ENTRIES   = 8,
    parameter int OWN_ADDRESSES = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  irfd_pkg::t_action   i_action,
    input  logic [2:0]          i_entry_index,
    input  irfd_pkg::t_ipv4     i_source_ip,
    input  irfd_pkg::t_ipv4     i_dest_ip,
    input  logic [7:0]          i_icmp_kind,
    input  logic [7:0]          i_hop_limit,
    input  irfd_pkg::t_ipv4     i_entry_address,
    input  irfd_pkg::t_ipv4     i_entry_mask,
    input  irfd_pkg::t_ipv4     i_entry_gateway,
    input  logic [3:0]          i_entry_port,
    input  irfd_pkg::t_mac      i_entry_mac,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output irfd_pkg::t_verdict  o_verdict,
    output irfd_pkg::t_ipv4     o_out_source_ip,
    output irfd_pkg::t_ipv4     o_out_dest_ip,
    output logic [7:0]          o_out_icmp_kind,
    output logic [7:0]          o_out_hop_limit,
    output logic [3:0]          o_out_port,
    output irfd_pkg::t_ipv4     o_next_hop_ip,
    output irfd_pkg::t_mac      o_next_hop_mac
);
    import irfd_pkg::*;

    localparam int RW   = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int AW   = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
    localparam int OW   = (OWN_ADDRESSES > 1) ? $clog2(OWN_ADDRESSES) : 1;
    localparam int MAXN = (ROUTE_ENTRIES > ARP_ENTRIES) ?
                          ((ROUTE_ENTRIES > OWN_ADDRESSES) ? ROUTE_ENTRIES : OWN_ADDRESSES) :
                          ((ARP_ENTRIES > OWN_ADDRESSES) ? ARP_ENTRIES : OWN_ADDRESSES);
    localparam int CW   = $clog2(MAXN + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_OWN   = 3'd1;
    localparam logic [2:0] S_ROUTE = 3'd2;
    localparam logic [2:0] S_ARP   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // table storage
    t_ipv4      rt_dest_mem [ROUTE_ENTRIES];
    t_ipv4      rt_mask_mem [ROUTE_ENTRIES];
    t_ipv4      rt_gw_mem   [ROUTE_ENTRIES];
    logic [3:0] rt_port_mem [ROUTE_ENTRIES];
    t_ipv4      arp_ip_mem  [ARP_ENTRIES];
    t_mac       arp_mac_mem [ARP_ENTRIES];
    t_ipv4      own_mem     [OWN_ADDRESSES];

    logic [ROUTE_ENTRIES-1:0] r_rt_valid;
    logic [ARP_ENTRIES-1:0]   r_arp_valid;
    logic [OWN_ADDRESSES-1:0] r_own_valid;

    // registered read data
    t_ipv4      r_rt_dest_q, r_rt_mask_q, r_rt_gw_q, r_arp_ip_q, r_own_q;
    logic [3:0] r_rt_port_q;
    t_mac       r_arp_mac_q;
    logic       r_rt_vq, r_arp_vq, r_own_vq;

    // sequencer
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_qidx;
    logic          r_pend, n_pend;

    // working result
    t_verdict   r_verdict, n_verdict;
    t_ipv4      r_res_src, n_res_src;
    t_ipv4      r_res_dst, n_res_dst;
    logic [7:0] r_res_kind, n_res_kind;
    logic [7:0] r_res_ttl, n_res_ttl;
    logic [7:0] r_ttl, n_ttl;
    logic [3:0] r_res_port, n_res_port;
    t_ipv4      r_res_hop, n_res_hop;
    t_mac       r_res_mac, n_res_mac;

    // output register
    logic       r_out_valid;
    t_verdict   r_o_verdict;
    t_ipv4      r_o_src, r_o_dst, r_o_hop;
    logic [7:0] r_o_kind, r_o_ttl;
    logic [3:0] r_o_port;
    t_mac       r_o_mac;

    logic     w_in_xfer;
    logic     w_out_free;
    logic     w_rt_we, w_arp_we, w_own_we;
    logic     w_hit;
    logic     w_last;
    logic     w_issue;
    t_cmp_req w_req;
    t_ipv4    w_gw_hop;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_rt_we  = w_in_xfer && (i_action == ACT_ROUTE) &&
                      (int'(i_entry_index) < ROUTE_ENTRIES);
    assign w_arp_we = w_in_xfer && (i_action == ACT_ARP) &&
                      (int'(i_entry_index) < ARP_ENTRIES);
    assign w_own_we = w_in_xfer && (i_action == ACT_OWN) &&
                      (int'(i_entry_index) < OWN_ADDRESSES);

    // table writes and one registered read per table at the scan count
    always_ff @(posedge i_clk) begin
        if (w_rt_we) begin
            rt_dest_mem[RW'(i_entry_index)] <= i_entry_address;
            rt_mask_mem[RW'(i_entry_index)] <= i_entry_mask;
            rt_gw_mem[RW'(i_entry_index)]   <= i_entry_gateway;
            rt_port_mem[RW'(i_entry_index)] <= i_entry_port;
        end
        if (w_arp_we) begin
            arp_ip_mem[AW'(i_entry_index)]  <= i_entry_address;
            arp_mac_mem[AW'(i_entry_index)] <= i_entry_mac;
        end
        if (w_own_we) begin
            own_mem[OW'(i_entry_index)] <= i_entry_address;
        end
        r_rt_dest_q <= rt_dest_mem[r_cnt[RW-1:0]];
        r_rt_mask_q <= rt_mask_mem[r_cnt[RW-1:0]];
        r_rt_gw_q   <= rt_gw_mem[r_cnt[RW-1:0]];
        r_rt_port_q <= rt_port_mem[r_cnt[RW-1:0]];
        r_arp_ip_q  <= arp_ip_mem[r_cnt[AW-1:0]];
        r_arp_mac_q <= arp_mac_mem[r_cnt[AW-1:0]];
        r_own_q     <= own_mem[r_cnt[OW-1:0]];
        r_rt_vq     <= r_rt_valid[r_cnt[RW-1:0]];
        r_arp_vq    <= r_arp_valid[r_cnt[AW-1:0]];
        r_own_vq    <= r_own_valid[r_cnt[OW-1:0]];
        r_qidx      <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_valid  <= '0;
            r_arp_valid <= '0;
            r_own_valid <= '0;
        end else begin
            if (w_rt_we) begin
                r_rt_valid[RW'(i_entry_index)] <= 1'b1;
            end
            if (w_arp_we) begin
                r_arp_valid[AW'(i_entry_index)] <= 1'b1;
            end
            if (w_own_we) begin
                r_own_valid[OW'(i_entry_index)] <= 1'b1;
            end
        end
    end

    // shared compare unit, fed by the phase in progress
    always_comb begin
        w_req = '0;
        case (r_state)
            S_OWN: begin
                w_req.valid   = r_pend && r_own_vq;
                w_req.key     = r_res_dst;
                w_req.mask    = IP_ONES;
                w_req.pattern = r_own_q;
            end
            S_ROUTE: begin
                w_req.valid   = r_pend && r_rt_vq;
                w_req.key     = r_res_dst;
                w_req.mask    = r_rt_mask_q;
                w_req.pattern = r_rt_dest_q;
            end
            S_ARP: begin
                w_req.valid   = r_pend && r_arp_vq;
                w_req.key     = r_res_hop;
                w_req.mask    = IP_ONES;
                w_req.pattern = r_arp_ip_q;
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    irfd_cmp u_cmp (
        .i_req (w_req),
        .o_hit (w_hit)
    );

    // last entry of the phase has been compared, and next entry to read exists
    always_comb begin
        w_last  = 1'b0;
        w_issue = 1'b0;
        case (r_state)
            S_OWN: begin
                w_last  = r_pend && (r_qidx == CW'(OWN_ADDRESSES - 1));
                w_issue = int'(r_cnt) < OWN_ADDRESSES;
            end
            S_ROUTE: begin
                w_last  = r_pend && (r_qidx == CW'(ROUTE_ENTRIES - 1));
                w_issue = int'(r_cnt) < ROUTE_ENTRIES;
            end
            S_ARP: begin
                w_last  = r_pend && (r_qidx == CW'(ARP_ENTRIES - 1));
                w_issue = int'(r_cnt) < ARP_ENTRIES;
            end
            default: begin
                w_last  = 1'b0;
                w_issue = 1'b0;
            end
        endcase
    end

    assign w_gw_hop = (r_rt_gw_q != IP_ZERO) ? r_rt_gw_q : r_res_dst;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_pend     = 1'b0;
        n_verdict  = r_verdict;
        n_res_src  = r_res_src;
        n_res_dst  = r_res_dst;
        n_res_kind = r_res_kind;
        n_res_ttl  = r_res_ttl;
        n_ttl      = r_ttl;
        n_res_port = r_res_port;
        n_res_hop  = r_res_hop;
        n_res_mac  = r_res_mac;
        if (w_issue) begin
            n_cnt  = r_cnt + CW'(1);
            n_pend = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_in_xfer) begin
                    n_res_src  = IP_ZERO;
                    n_res_dst  = IP_ZERO;
                    n_res_kind = 8'd0;
                    n_res_ttl  = 8'd0;
                    n_res_port = 4'd0;
                    n_res_hop  = IP_ZERO;
                    n_res_mac  = MAC_ZERO;
                    n_state    = S_DONE;
                    if (i_action != ACT_PACKET) begin
                        n_verdict = V_WRITE;
                    end else if (i_icmp_kind != KIND_ECHO_REQ && i_icmp_kind != ICMP_REPLY) begin
                        n_verdict = V_DROP;
                    end else begin
                        // forward fields by default, replaced on reply
                        n_res_src  = i_source_ip;
                        n_res_dst  = i_dest_ip;
                        n_res_kind = i_icmp_kind;
                        n_res_ttl  = i_hop_limit - 8'd1;
                        n_ttl      = i_hop_limit;
                        n_state    = S_OWN;
                    end
                end
            end
            S_OWN: begin
                if (w_hit) begin
                    n_verdict  = V_REPLY;
                    n_res_src  = r_res_dst;
                    n_res_dst  = r_res_src;
                    n_res_kind = ICMP_REPLY;
                    n_res_ttl  = r_ttl;
                    n_state    = S_DONE;
                end else if (w_last) begin
                    n_state = S_ROUTE;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                end
            end
            S_ROUTE: begin
                if (w_hit) begin
                    n_res_port = r_rt_port_q;
                    n_res_hop  = w_gw_hop;
                    n_state    = S_ARP;
                    n_cnt      = '0;
                    n_pend     = 1'b0;
                end else if (w_last) begin
                    n_verdict = V_NO_ROUTE;
                    n_state   = S_DONE;
                end
            end
            S_ARP: begin
                if (w_hit) begin
                    n_verdict = V_FORWARD;
                    n_res_mac = r_arp_mac_q;
                    n_state   = S_DONE;
                end else if (w_last) begin
                    n_verdict = V_NO_ARP;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (n_state == S_DONE || n_state == S_IDLE) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict  <= n_verdict;
        r_res_src  <= n_res_src;
        r_res_dst  <= n_res_dst;
        r_res_kind <= n_res_kind;
        r_res_ttl  <= n_res_ttl;
        r_ttl      <= n_ttl;
        r_res_port <= n_res_port;
        r_res_hop  <= n_res_hop;
        r_res_mac  <= n_res_mac;
    end

    // output register, loaded from the working result when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_verdict <= r_verdict;
            r_o_src     <= r_res_src;
            r_o_dst     <= r_res_dst;
            r_o_kind    <= r_res_kind;
            r_o_ttl     <= r_res_ttl;
            r_o_port    <= r_res_port;
            r_o_hop     <= r_res_hop;
            r_o_mac     <= r_res_mac;
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_verdict       = r_o_verdict;
    assign o_out_source_ip = r_o_src;
    assign o_out_dest_ip   = r_o_dst;
    assign o_out_icmp_kind = r_o_kind;
    assign o_out_hop_limit = r_o_ttl;
    assign o_out_port      = r_o_port;
    assign o_next_hop_ip   = r_o_hop;
    assign o_next_hop_mac  = r_o_mac;

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_in_valid) |=> (r_state == S_IDLE))
        else $error("sequencer left idle without an input transfer");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUTE && r_pend) |-> (int'(r_qidx) < ROUTE_ENTRIES))
        else $error("route compare beyond table depth");

    a_reply_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == V_REPLY) |->
        (o_out_icmp_kind == ICMP_REPLY && o_out_port == 4'd0 &&
         o_next_hop_ip == IP_ZERO && o_next_hop_mac == MAC_ZERO))
        else $error("reply carries forwarding fields");

    a_no_route_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_verdict == V_NO_ROUTE) |->
        (o_out_port == 4'd0 && o_next_hop_ip == IP_ZERO && o_next_hop_mac == MAC_ZERO))
        else $error("no-route result carries next hop");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not presented");

endmodule

### dv/icmp_router_forward_decision_checker.sv
// ----------------------------------------------------------------------------
// icmp_router_forward_decision_checker: decision predictor and result compare
// watches both channels, keeps its own copy of the route, arp and own address
// tables, predicts one decision per input transfer and checks each output
// transfer field by field against the oldest prediction
// ----------------------------------------------------------------------------
module icmp_router_forward_decision_checker #(
    parameter int ROUTE_ENTRIES = 8,
    parameter int ARP_ENTRIES   = 8,
    parameter int OWN_ADDRESSES = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  irfd_pkg::t_action   i_action,
    input  logic [2:0]          i_entry_index,
    input  irfd_pkg::t_ipv4     i_source_ip,
    input  irfd_pkg::t_ipv4     i_dest_ip,
    input  logic [7:0]          i_icmp_kind,
    input  logic [7:0]          i_hop_limit,
    input  irfd_pkg::t_ipv4     i_entry_address,
    input  irfd_pkg::t_ipv4     i_entry_mask,
    input  irfd_pkg::t_ipv4     i_entry_gateway,
    input  logic [3:0]          i_entry_port,
    input  irfd_pkg::t_mac      i_entry_mac,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  irfd_pkg::t_verdict  i_verdict,
    input  irfd_pkg::t_ipv4     i_out_source_ip,
    input  irfd_pkg::t_ipv4     i_out_dest_ip,
    input  logic [7:0]          i_out_icmp_kind,
    input  logic [7:0]          i_out_hop_limit,
    input  logic [3:0]          i_out_port,
    input  irfd_pkg::t_ipv4     i_next_hop_ip,
    input  irfd_pkg::t_mac      i_next_hop_mac,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_replies,
    output int                  o_forwards,
    output int                  o_misses,
    output int                  o_drops,
    output int                  o_writes
);
    import irfd_pkg::*;

    localparam int RI = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int AI = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
    localparam int OI = (OWN_ADDRESSES > 1) ? $clog2(OWN_ADDRESSES) : 1;

    typedef struct packed {
        t_verdict   verdict;
        t_ipv4      src;
        t_ipv4      dst;
        logic [7:0] kind;
        logic [7:0] ttl;
        logic [3:0] port;
        t_ipv4      hop;
        t_mac       mac;
    } t_decision;

    t_ipv4                    route_net  [ROUTE_ENTRIES];
    t_ipv4                    route_mask [ROUTE_ENTRIES];
    t_ipv4                    route_gw   [ROUTE_ENTRIES];
    logic [3:0]               route_if   [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] route_used;
    t_ipv4                    arp_ip     [ARP_ENTRIES];
    t_mac                     arp_mac    [ARP_ENTRIES];
    logic [ARP_ENTRIES-1:0]   arp_used;
    t_ipv4                    own_ip     [OWN_ADDRESSES];
    logic [OWN_ADDRESSES-1:0] own_used;

    t_decision pending_decisions[$];
    int        results_seen = 0;

    function automatic t_decision decide(input t_ipv4 src, input t_ipv4 dst,
                                         input logic [7:0] kind, input logic [7:0] ttl);
        t_decision d;
        int        hit;
        d   = '0;
        hit = -1;
        if (kind != KIND_ECHO_REQ && kind != ICMP_REPLY) begin
            d.verdict = V_DROP;
            return d;
        end
        for (int i = 0; i < OWN_ADDRESSES; i++)
            if (own_used[i] && own_ip[i] == dst) hit = i;
        if (hit >= 0) begin
            d.verdict = V_REPLY;
            d.src     = dst;
            d.dst     = src;
            d.kind    = ICMP_REPLY;
            d.ttl     = ttl;
            return d;
        end
        d.src  = src;
        d.dst  = dst;
        d.kind = kind;
        d.ttl  = ttl - 8'd1;
        // walk downwards so the lowest matching slot wins
        for (int i = ROUTE_ENTRIES - 1; i >= 0; i--)
            if (route_used[i] && (dst & route_mask[i]) == route_net[i]) hit = i;
        if (hit < 0) begin
            d.verdict = V_NO_ROUTE;
            return d;
        end
        d.port    = route_if[hit];
        d.hop     = (route_gw[hit] != IP_ZERO) ? route_gw[hit] : dst;
        d.verdict = V_NO_ARP;
        for (int i = ARP_ENTRIES - 1; i >= 0; i--)
            if (arp_used[i] && arp_ip[i] == d.hop) begin
                d.verdict = V_FORWARD;
                d.mac     = arp_mac[i];
            end
        return d;
    endfunction

    task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
        o_errors++;
        $display("mismatch on %s of result %0d: got %0h, want %0h",
                 field, results_seen, got, want);
    endtask

    always @(posedge i_clk) begin
        t_decision d;
        if (!i_rst_n) begin
            route_used = '0;
            arp_used   = '0;
            own_used   = '0;
            pending_decisions.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                d         = '0;
                d.verdict = V_WRITE;
                case (i_action)
                    ACT_PACKET: begin
                        d = decide(i_source_ip, i_dest_ip, i_icmp_kind, i_hop_limit);
                    end
                    ACT_ROUTE: begin
                        if (int'(i_entry_index) < ROUTE_ENTRIES) begin
                            route_net[RI'(i_entry_index)]  = i_entry_address;
                            route_mask[RI'(i_entry_index)] = i_entry_mask;
                            route_gw[RI'(i_entry_index)]   = i_entry_gateway;
                            route_if[RI'(i_entry_index)]   = i_entry_port;
                            route_used[RI'(i_entry_index)] = 1'b1;
                        end
                    end
                    ACT_ARP: begin
                        if (int'(i_entry_index) < ARP_ENTRIES) begin
                            arp_ip[AI'(i_entry_index)]   = i_entry_address;
                            arp_mac[AI'(i_entry_index)]  = i_entry_mac;
                            arp_used[AI'(i_entry_index)] = 1'b1;
                        end
                    end
                    default: begin
                        // slots past the own address table are dropped silently
                        if (int'(i_entry_index) < OWN_ADDRESSES) begin
                            own_ip[OI'(i_entry_index)]   = i_entry_address;
                            own_used[OI'(i_entry_index)] = 1'b1;
                        end
                    end
                endcase
                pending_decisions.push_back(d);
            end
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_decisions.size() == 0) begin
                    report("unexpected result, verdict", 64'(i_verdict), 64'(0));
                end else begin
                    d = pending_decisions.pop_front();
                    case (d.verdict)
                        V_REPLY:               o_replies++;
                        V_FORWARD:             o_forwards++;
                        V_NO_ROUTE, V_NO_ARP:  o_misses++;
                        V_DROP:                o_drops++;
                        default:               o_writes++;
                    endcase
                    if (i_verdict !== d.verdict)
                        report("verdict", 64'(i_verdict), 64'(d.verdict));
                    if (i_out_source_ip !== d.src)
                        report("source ip", 64'(i_out_source_ip), 64'(d.src));
                    if (i_out_dest_ip !== d.dst)
                        report("dest ip", 64'(i_out_dest_ip), 64'(d.dst));
                    if (i_out_icmp_kind !== d.kind)
                        report("icmp kind", 64'(i_out_icmp_kind), 64'(d.kind));
                    if (i_out_hop_limit !== d.ttl)
                        report("hop limit", 64'(i_out_hop_limit), 64'(d.ttl));
                    if (i_out_port !== d.port)
                        report("port", 64'(i_out_port), 64'(d.port));
                    if (i_next_hop_ip !== d.hop)
                        report("next hop ip", 64'(i_next_hop_ip), 64'(d.hop));
                    if (i_next_hop_mac !== d.mac)
                        report("next hop mac", 64'(i_next_hop_mac), 64'(d.mac));
                end
            end
        end
        o_pending = pending_decisions.size();
    end

endmodule

### dv/icmp_router_forward_decision_tb.sv
// ----------------------------------------------------------------------------
// icmp_router_forward_decision_tb: forward decision testbench
// directed packets and table writes for the corner cases, then random
// traffic aimed at the tables written so far, with random idling on both
// sides and one long output stall; the checker predicts and compares
// ----------------------------------------------------------------------------
module icmp_router_forward_decision_tb;
    import irfd_pkg::*;

    localparam int RANDOM_ITEMS   = 1930;
    localparam int SQUEEZE_AT     = 700;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int QUIET_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        t_action    action;
        logic [2:0] index;
        t_ipv4      src;
        t_ipv4      dst;
        logic [7:0] kind;
        logic [7:0] ttl;
        t_ipv4      addr;
        t_ipv4      mask;
        t_ipv4      gw;
        logic [3:0] port;
        t_mac       mac;
    } t_request;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_request   req;
    logic       o_out_valid;
    logic       i_out_ready;
    t_verdict   o_verdict;
    t_ipv4      o_out_source_ip;
    t_ipv4      o_out_dest_ip;
    logic [7:0] o_out_icmp_kind;
    logic [7:0] o_out_hop_limit;
    logic [3:0] o_out_port;
    t_ipv4      o_next_hop_ip;
    t_mac       o_next_hop_mac;

    int errors, pending, replies, forwards, misses, drops, writes;
    int offered = 0;
    int quiet   = 0;
    logic calm;

    // what has been written, only used to aim packets at live entries
    t_ipv4 aim_net  [8];
    t_ipv4 aim_mask [8];
    t_ipv4 aim_gw   [8];
    t_ipv4 aim_arp  [8];
    t_ipv4 aim_own  [2];
    logic [7:0] aim_route_ok = '0;
    logic [7:0] aim_arp_ok   = '0;
    logic [1:0] aim_own_ok   = '0;

    assign calm = (offered >= 1100 && offered < 1300) || offered >= RANDOM_ITEMS - 280;

    icmp_router_forward_decision DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (req.action),
        .i_entry_index   (req.index),
        .i_source_ip     (req.src),
        .i_dest_ip       (req.dst),
        .i_icmp_kind     (req.kind),
        .i_hop_limit     (req.ttl),
        .i_entry_address (req.addr),
        .i_entry_mask    (req.mask),
        .i_entry_gateway (req.gw),
        .i_entry_port    (req.port),
        .i_entry_mac     (req.mac),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_verdict       (o_verdict),
        .o_out_source_ip (o_out_source_ip),
        .o_out_dest_ip   (o_out_dest_ip),
        .o_out_icmp_kind (o_out_icmp_kind),
        .o_out_hop_limit (o_out_hop_limit),
        .o_out_port      (o_out_port),
        .o_next_hop_ip   (o_next_hop_ip),
        .o_next_hop_mac  (o_next_hop_mac)
    );

    icmp_router_forward_decision_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_action        (req.action),
        .i_entry_index   (req.index),
        .i_source_ip     (req.src),
        .i_dest_ip       (req.dst),
        .i_icmp_kind     (req.kind),
        .i_hop_limit     (req.ttl),
        .i_entry_address (req.addr),
        .i_entry_mask    (req.mask),
        .i_entry_gateway (req.gw),
        .i_entry_port    (req.port),
        .i_entry_mac     (req.mac),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_verdict       (o_verdict),
        .i_out_source_ip (o_out_source_ip),
        .i_out_dest_ip   (o_out_dest_ip),
        .i_out_icmp_kind (o_out_icmp_kind),
        .i_out_hop_limit (o_out_hop_limit),
        .i_out_port      (o_out_port),
        .i_next_hop_ip   (o_next_hop_ip),
        .i_next_hop_mac  (o_next_hop_mac),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_replies       (replies),
        .o_forwards      (forwards),
        .o_misses        (misses),
        .o_drops         (drops),
        .o_writes        (writes)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // fully random request, every field toggling
    function automatic t_request noise_request();
        t_request    r;
        logic [63:0] wide;
        wide     = {$urandom(), $urandom()};
        r.action = t_action'($urandom_range(0, 3));
        r.index  = 3'($urandom_range(0, 7));
        r.src    = $urandom();
        r.dst    = $urandom();
        r.kind   = 8'($urandom_range(0, 255));
        r.ttl    = 8'($urandom_range(0, 255));
        r.addr   = $urandom();
        r.mask   = $urandom();
        r.gw     = $urandom();
        r.port   = 4'($urandom_range(0, 15));
        r.mac    = wide[47:0];
        return r;
    endfunction

    function automatic t_ipv4 pick_host();
        int i;
        i = $urandom_range(0, 7);
        if (!aim_route_ok[i]) return $urandom();
        return aim_net[i] | ($urandom() & ~aim_mask[i]);
    endfunction

    // called at a clock edge; returns at the edge of the transfer
    task automatic offer(input t_request r);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        req        <= r;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        offered++;
    endtask

    task automatic write_route(input logic [2:0] idx, input t_ipv4 net, input t_ipv4 mask,
                               input t_ipv4 gw, input logic [3:0] port);
        t_request r;
        r           = noise_request();
        r.action    = ACT_ROUTE;
        r.index     = idx;
        r.addr      = net;
        r.mask      = mask;
        r.gw        = gw;
        r.port      = port;
        aim_net[idx]      = net;
        aim_mask[idx]     = mask;
        aim_gw[idx]       = gw;
        aim_route_ok[idx] = 1'b1;
        offer(r);
    endtask

    task automatic write_arp(input logic [2:0] idx, input t_ipv4 ip, input t_mac mac);
        t_request r;
        r               = noise_request();
        r.action        = ACT_ARP;
        r.index         = idx;
        r.addr          = ip;
        r.mac           = mac;
        aim_arp[idx]    = ip;
        aim_arp_ok[idx] = 1'b1;
        offer(r);
    endtask

    task automatic write_own(input logic [2:0] idx, input t_ipv4 ip);
        t_request r;
        r        = noise_request();
        r.action = ACT_OWN;
        r.index  = idx;
        r.addr   = ip;
        if (idx < 2) begin
            aim_own[idx[0]]    = ip;
            aim_own_ok[idx[0]] = 1'b1;
        end
        offer(r);
    endtask

    task automatic send_packet(input t_ipv4 src, input t_ipv4 dst,
                               input logic [7:0] kind, input logic [7:0] ttl);
        t_request r;
        r        = noise_request();
        r.action = ACT_PACKET;
        r.src    = src;
        r.dst    = dst;
        r.kind   = kind;
        r.ttl    = ttl;
        offer(r);
    endtask

    task automatic random_route();
        int          len;
        logic [2:0]  idx;
        t_ipv4       mask;
        t_ipv4       net;
        t_ipv4       gw;
        idx  = 3'($urandom_range(0, 7));
        len  = $urandom_range(0, 32);
        mask = (len == 0) ? IP_ZERO : (IP_ONES << (32 - len));
        net  = $urandom() & mask;
        // now and then a random destination, which never matches if it has bits outside its mask
        if ($urandom_range(0, 9) == 0) net = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: gw = IP_ZERO;
            4, 5, 6:    gw = aim_arp[$urandom_range(0, 7)];
            default:    gw = $urandom();
        endcase
        if (gw === 'x) gw = $urandom();
        write_route(idx, net, mask, gw, 4'($urandom_range(0, 15)));
    endtask

    task automatic random_arp();
        int          i;
        t_ipv4       ip;
        logic [63:0] wide;
        i    = $urandom_range(0, 7);
        wide = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ip = (aim_route_ok[i] && aim_gw[i] != IP_ZERO) ? aim_gw[i] : pick_host();
            4, 5, 6:    ip = pick_host();
            default:    ip = $urandom();
        endcase
        write_arp(3'($urandom_range(0, 7)), ip, wide[47:0]);
    endtask

    task automatic random_packet();
        int         i;
        logic [7:0] kind;
        logic [7:0] ttl;
        t_ipv4      dst;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8: kind = KIND_ECHO_REQ;
            9, 10, 11, 12, 13, 14, 15: kind = ICMP_REPLY;
            default:                   kind = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
            0:       ttl = 8'd0;
            1:       ttl = 8'd1;
            2:       ttl = 8'hFF;
            default: ttl = 8'($urandom_range(0, 255));
        endcase
        i = $urandom_range(0, 19);
        if (i < 4 && aim_own_ok[i[0]])
            dst = aim_own[i[0]];
        else if (i < 12)
            dst = pick_host();
        else if (i < 15 && aim_arp_ok[i - 12])
            dst = aim_arp[i - 12];
        else
            dst = $urandom();
        send_packet($urandom(), dst, kind, ttl);
    endtask

    // receiver: short random stalls, plus one long hold-off to back the block up
    initial begin : receiver
        int stall;
        bit squeezed;
        stall       = 0;
        squeezed    = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!squeezed && offered >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                i_out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end else if (stall > 0) begin
                stall--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 8) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial begin : watchdog
        while (quiet < QUIET_LIMIT) @(negedge i_clk);
        $display("no transfer for %0d cycles, %0d results outstanding", quiet, pending);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int pick;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        req        = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty tables: no route, ttl wraps; unknown icmp types are dropped
        send_packet(32'h0A00_0002, 32'hC0A8_0105, KIND_ECHO_REQ, 8'd0);
        send_packet(IP_ONES, IP_ZERO, 8'd5, 8'd64);
        send_packet(IP_ZERO, IP_ONES, 8'hFF, 8'hFF);
        // own address, and a slot past the end that must be ignored
        write_own(3'd0, 32'h0A00_0001);
        write_own(3'd7, 32'hC0A8_0105);
        send_packet(32'hC0A8_0105, 32'h0A00_0001, KIND_ECHO_REQ, 8'd64);
        send_packet(IP_ONES, 32'h0A00_0001, ICMP_REPLY, 8'd0);
        send_packet(32'h0A00_0002, 32'hC0A8_0105, KIND_ECHO_REQ, 8'd1);
        // directly connected subnet and a default route via a gateway
        write_route(3'd0, 32'hC0A8_0100, 32'hFFFF_FF00, IP_ZERO, 4'hF);
        write_route(3'd1, IP_ZERO, IP_ZERO, 32'h0A00_00FE, 4'h3);
        send_packet(32'h0A00_0002, 32'hC0A8_0105, KIND_ECHO_REQ, 8'd1);
        write_arp(3'd0, 32'hC0A8_0105, 48'hFFFF_FFFF_FFFF);
        send_packet(32'h0A00_0002, 32'hC0A8_0105, ICMP_REPLY, 8'hFF);
        send_packet(32'h0A00_0002, 32'h0808_0808, KIND_ECHO_REQ, 8'd2);
        write_arp(3'd7, 32'h0A00_00FE, MAC_ZERO);
        send_packet(32'h0A00_0002, 32'h0808_0808, KIND_ECHO_REQ, 8'd0);
        // host route behind the default: first match must pick the default
        write_route(3'd2, IP_ONES, IP_ONES, IP_ONES, 4'h0);
        send_packet(32'h0A00_0002, IP_ONES, KIND_ECHO_REQ, 8'd9);
        write_route(3'd1, 32'h0A00_0000, 32'hFF00_0000, IP_ZERO, 4'h7);
        send_packet(32'h0A00_0002, IP_ONES, KIND_ECHO_REQ, 8'd9);
        // own address wins over any route
        write_own(3'd1, IP_ONES);
        send_packet(32'h0A00_0002, IP_ONES, ICMP_REPLY, 8'd9);
        // duplicate arp entries: the lower slot answers
        write_arp(3'd3, 32'h0A01_0203, 48'h0000_0000_0001);
        write_arp(3'd5, 32'h0A01_0203, 48'h8000_0000_0000);
        send_packet(32'hC0A8_0105, 32'h0A01_0203, KIND_ECHO_REQ, 8'd128);
        send_packet(IP_ZERO, IP_ZERO, KIND_ECHO_REQ, 8'd7);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)       random_route();
            else if (pick < 8)  random_arp();
            else if (pick < 10) write_own(3'($urandom_range(0, 7)),
                                          ($urandom_range(0, 1) == 0) ? pick_host() : $urandom());
            else if (pick < 14) offer(noise_request());
            else                random_packet();
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d items sent: %0d replies, %0d forwards, %0d route or arp misses,",
                 offered, replies, forwards, misses);
        $display("%0d drops and %0d table writes; %0d mismatches", drops, writes, errors);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
